/* hdl/ffbp_pkg.sv */
// Package for the first-fit bin packer: payload types, control types and constants.
package ffbp_pkg;

  localparam int ID_W            = 16;
  localparam int VOL_W           = 10;
  localparam int CAP_W           = 10;
  localparam int BOX_IDX_W       = 6;
  localparam int STATUS_W        = 2;
  localparam int DEF_MAX_BOXES   = 64;
  localparam int DEF_VOLUME_BITS = 10;
  localparam int CAPACITY_RESET  = 60;

  localparam logic [STATUS_W-1:0] STATUS_PLACED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_BIG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_BOX  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  item_id;
    logic [VOL_W-1:0] item_volume;
    logic             new_batch;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]      placed_id;
    logic [BOX_IDX_W-1:0] box_index;
    logic                 opened_box;
    logic [VOL_W-1:0]     room_left;
    logic [STATUS_W-1:0]  status;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN
  } state_t;

  typedef enum logic [1:0] {
    RES_FIT,
    RES_OPEN,
    RES_BIG,
    RES_FULL
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      scan_start;
    logic      scan_advance;
    logic      write_fit;
    logic      write_open;
    logic      emit;
    res_kind_t kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic too_big;
    logic none_open;
    logic fits;
    logic last;
    logic full;
  } dp_stat_t;

endpackage

/* hdl/ffbp_ctrl.sv */
// Controller state machine of the first-fit bin packer.
module ffbp_ctrl import ffbp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = RES_FIT;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.too_big) begin
          cmd.emit   = 1'b1;
          cmd.kind   = RES_BIG;
          state_next = ST_IDLE;
        end else if (stat.none_open) begin
          cmd.write_open = 1'b1;
          cmd.emit       = 1'b1;
          cmd.kind       = RES_OPEN;
          state_next     = ST_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.fits) begin
          cmd.write_fit = 1'b1;
          cmd.emit      = 1'b1;
          cmd.kind      = RES_FIT;
          state_next    = ST_IDLE;
        end else if (stat.last) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
          if (stat.full) begin
            cmd.kind = RES_FULL;
          end else begin
            cmd.write_open = 1'b1;
            cmd.kind       = RES_OPEN;
          end
        end else begin
          cmd.scan_advance = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

/* hdl/ffbp_datapath.sv */
// Datapath of the first-fit bin packer: room memory, box count, scan index, result register.
module ffbp_datapath import ffbp_pkg::*; #(
  parameter int MAX_BOXES   = DEF_MAX_BOXES,
  parameter int VOLUME_BITS = DEF_VOLUME_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  item_t            item,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat,
  output result_t          result,
  output logic             strobe
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int CMP_W = (VOLUME_BITS > VOL_W) ? VOLUME_BITS : VOL_W;
  localparam int IXW   = (IDX_W > BOX_IDX_W) ? IDX_W : BOX_IDX_W;

  logic [VOLUME_BITS-1:0] box_room [MAX_BOXES];
  logic [VOLUME_BITS-1:0] rd_room;

  logic [CAP_W-1:0] capacity;
  logic [ID_W-1:0]  cur_id;
  logic [VOL_W-1:0] cur_vol;
  logic [CNT_W-1:0] boxes_open;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] scan_idx_next;

  logic [CMP_W-1:0]       vol_ext;
  logic [CMP_W-1:0]       rd_ext;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       fit_diff;
  logic [VOLUME_BITS-1:0] room_fit;
  logic [VOLUME_BITS-1:0] room_open;
  logic [IDX_W-1:0]       open_idx;
  logic [VOLUME_BITS-1:0] room_sel;
  logic [CMP_W-1:0]       room_sel_ext;
  logic [IDX_W-1:0]       idx_sel;
  logic [IXW-1:0]         idx_sel_ext;
  result_t                result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAPACITY_RESET);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_id  <= item.item_id;
      cur_vol <= item.item_volume;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boxes_open <= '0;
    end else if (cmd.load && item.new_batch) begin
      boxes_open <= '0;
    end else if (cmd.write_open) begin
      boxes_open <= boxes_open + CNT_W'(1);
    end
  end

  always_comb begin
    if (cmd.scan_start) begin
      scan_idx_next = '0;
    end else if (cmd.scan_advance) begin
      scan_idx_next = scan_idx + IDX_W'(1);
    end else begin
      scan_idx_next = scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else begin
      scan_idx <= scan_idx_next;
    end
  end

  assign vol_ext   = CMP_W'(cur_vol);
  assign rd_ext    = CMP_W'(rd_room);
  assign cap_ext   = CMP_W'(capacity);
  assign fit_diff  = rd_ext - vol_ext;
  assign room_fit  = fit_diff[VOLUME_BITS-1:0];
  assign room_open = cap_ext[VOLUME_BITS-1:0] - vol_ext[VOLUME_BITS-1:0];
  assign open_idx  = boxes_open[IDX_W-1:0];

  // Read data follows the index that the scan moves to, so it lines up with scan_idx.
  always_ff @(posedge clk) begin
    if (cmd.write_fit) begin
      box_room[scan_idx] <= room_fit;
    end else if (cmd.write_open) begin
      box_room[open_idx] <= room_open;
    end
    rd_room <= box_room[scan_idx_next];
  end

  assign stat.too_big   = (cur_vol > capacity);
  assign stat.none_open = (boxes_open == '0);
  assign stat.fits      = (rd_ext >= vol_ext);
  assign stat.last      = ((CNT_W'(scan_idx) + CNT_W'(1)) == boxes_open);
  assign stat.full      = (boxes_open == CNT_W'(MAX_BOXES));

  assign room_sel     = (cmd.kind == RES_OPEN) ? room_open : room_fit;
  assign room_sel_ext = CMP_W'(room_sel);
  assign idx_sel      = (cmd.kind == RES_OPEN) ? open_idx : scan_idx;
  assign idx_sel_ext  = IXW'(idx_sel);

  always_comb begin
    result_next           = '0;
    result_next.placed_id = cur_id;
    case (cmd.kind)
      RES_FIT, RES_OPEN: begin
        result_next.box_index  = idx_sel_ext[BOX_IDX_W-1:0];
        result_next.opened_box = (cmd.kind == RES_OPEN);
        result_next.room_left  = room_sel_ext[VOL_W-1:0];
        result_next.status     = STATUS_PLACED;
      end
      RES_BIG: begin
        result_next.status = STATUS_TOO_BIG;
      end
      RES_FULL: begin
        result_next.status = STATUS_NO_BOX;
      end
      default: begin
        result_next.status = STATUS_PLACED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

endmodule

/* hdl/first_fit_bin_packer.sv */
// Top level of the first-fit bin packer: controller, datapath and checks.
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+----------------------------------------
//   item in  | start, busy, item          | taken at an edge with start high, busy low
//   config   | cfg_valid, cfg_ready, data | written at an edge with valid and ready high
//   result   | strobe, result             | valid for one cycle while strobe is high
//
// An item passes a check state and then, if any box is open, a scan over the open
// boxes in the room memory (one read port, one box a cycle); busy is high from
// the cycle after accept until the result is registered, and the next item may
// be taken while the strobe is high.
// Reset is synchronous: it empties the box table and loads the capacity
// register with 60. The room memory needs no clearing: only opened boxes are read.
// The receiver cannot stall; each result is shown for exactly one cycle.
module first_fit_bin_packer import ffbp_pkg::*; #(
  parameter int MAX_BOXES   = DEF_MAX_BOXES,
  parameter int VOLUME_BITS = DEF_VOLUME_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  item_t            item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output logic             strobe,
  output result_t          result
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Take config only while idle, so no item in progress sees the capacity change.
  assign cfg_ready = !busy;

  // Sequence the check, the scan over open boxes and the open-or-reject decision.
  ffbp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the item, the box table, the capacity and the result register.
  ffbp_datapath #(
    .MAX_BOXES   (MAX_BOXES),
    .VOLUME_BITS (VOLUME_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result),
    .strobe   (strobe)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // A result only follows a cycle in which an item was being worked on.
  a_strobe_after_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without an item in progress");

  // A rejected item carries no box, no open flag and no room.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.status != STATUS_PLACED)) |->
      ((result.box_index == '0) && !result.opened_box && (result.room_left == '0)))
    else $error("rejected item carries placement fields");

  // Opening a box always means the item was placed.
  a_open_placed: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.opened_box) |-> (result.status == STATUS_PLACED))
    else $error("box opened for an item that was not placed");
`endif

endmodule
